@@ rtl/core/cdq_pkg.sv @@
// Shared types and constants for the circular deque core.
`default_nettype none

package cdq_pkg;

  localparam int DEPTH = 1024;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SIZE       = 3'd4,
    CMD_EMPTY      = 3'd5,
    CMD_PEEK_FRONT = 3'd6,
    CMD_PEEK_BACK  = 3'd7
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDATA
  } state_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read;
  } dp_stat_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_MAX) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_MAX : p - PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cdq_ctrl.sv @@
// Sequencing state machine for the circular deque core.
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire dp_stat_t   stat,
  output ctrl_cmd_t       cmd,
  output logic            busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.finish  = 1'b0;
    busy        = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        // a pop or peek of a non-empty deque goes through S_RDATA to wait for the store
        state_nxt = stat.need_read ? S_RDATA : S_IDLE;
      end
      S_RDATA: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/cdq_datapath.sv @@
// Pointers, ring store and result register of the circular deque core.
`default_nettype none

module cdq_datapath
  import cdq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_item,
  input  wire ctrl_cmd_t  cmd,
  output dp_stat_t        stat,
  output out_item_t       out_item,
  output logic            out_valid
);

  logic [DATA_W-1:0] ring_mem [DEPTH];

  cmd_e_t            cmd_r;
  logic [DATA_W-1:0] value_r;
  logic [PTR_W-1:0]  fp_r, fp_nxt;
  logic [PTR_W-1:0]  bp_r, bp_nxt;
  logic [DATA_W-1:0] rd_data_r;
  out_item_t         out_item_r, out_item_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              is_empty;
  logic              is_full;
  logic              is_read_cmd;
  logic [PTR_W:0]    diff;
  logic [PTR_W-1:0]  count;
  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  wr_addr, rd_addr;

  assign is_empty = (fp_r == bp_r);

  // entries = (front - back) mod DEPTH
  always_comb begin
    diff = {1'b0, fp_r} - {1'b0, bp_r};
    if (fp_r < bp_r) begin
      diff = diff + (PTR_W+1)'(DEPTH);
    end
    count = diff[PTR_W-1:0];
  end

  assign is_full = (count == PTR_MAX);

  assign is_read_cmd = (cmd_r == CMD_POP_FRONT) || (cmd_r == CMD_POP_BACK) ||
                       (cmd_r == CMD_PEEK_FRONT) || (cmd_r == CMD_PEEK_BACK);

  assign stat.need_read = is_read_cmd && !is_empty;

  always_comb begin
    fp_nxt        = fp_r;
    bp_nxt        = bp_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    wr_addr       = bp_r;
    rd_addr       = fp_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (cmd.exec) begin
      case (cmd_r)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (is_full) begin
            out_valid_nxt         = 1'b1;
            out_item_nxt.data_out = '0;
            out_item_nxt.status   = ST_FULL;
          end else if (cmd_r == CMD_PUSH_FRONT) begin
            fp_nxt  = ptr_inc(fp_r);
            wr_addr = ptr_inc(fp_r);
            mem_we  = 1'b1;
          end else begin
            wr_addr = bp_r;
            bp_nxt  = ptr_dec(bp_r);
            mem_we  = 1'b1;
          end
        end
        CMD_SIZE: begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.data_out = DATA_W'(count);
          out_item_nxt.status   = ST_OK;
        end
        CMD_EMPTY: begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.data_out = DATA_W'(is_empty);
          out_item_nxt.status   = ST_OK;
        end
        default: begin
          if (is_empty) begin
            out_valid_nxt         = 1'b1;
            out_item_nxt.data_out = '1;
            out_item_nxt.status   = ST_EMPTY;
          end else begin
            mem_re = 1'b1;
            if (cmd_r == CMD_POP_FRONT || cmd_r == CMD_PEEK_FRONT) begin
              rd_addr = fp_r;
            end else begin
              rd_addr = ptr_inc(bp_r);
            end
            if (cmd_r == CMD_POP_FRONT) begin
              fp_nxt = ptr_dec(fp_r);
            end
            if (cmd_r == CMD_POP_BACK) begin
              bp_nxt = ptr_inc(bp_r);
            end
          end
        end
      endcase
    end else if (cmd.finish) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.data_out = rd_data_r;
      out_item_nxt.status   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_addr] <= value_r;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= cmd_e_t'(in_item.command);
      value_r <= in_item.value;
    end
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r        <= '0;
      bp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fp_r        <= fp_nxt;
      bp_r        <= bp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/core/circular_deque_core.sv @@
// Circular deque core: ring store of DEPTH words with front and back pointers.
// A command is taken when start is high and busy is low. Pushes, size, empty,
// and pops or peeks of an empty deque keep busy high through S_EXEC after the
// accept; a pop or peek that reads the ring store keeps it high through S_EXEC
// and S_RDATA, the extra state covering the store's registered read port. No
// new command is taken until busy falls. The result, if any, sits on out_item
// for exactly one cycle with out_valid high, registered from S_EXEC or, for a
// store read, from S_RDATA; it cannot be held off, so the receiver must take
// it then. A successful push gives no result; a push into a deque holding
// DEPTH-1 entries is dropped and answered with status full. Pointers clear at
// reset; the store needs no clearing pass since only written slots are read.
`default_nettype none

module circular_deque_core
  import cdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output out_item_t     out_item,
  output logic          out_valid
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (dp_stat),
    .cmd   (ctrl_cmd),
    .busy  (busy)
  );

  cdq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (ctrl_cmd),
    .stat      (dp_stat),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted transaction");

  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back results");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in flight");

  a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_EMPTY |-> out_item.data_out == -1)
    else $error("empty status with a data word other than -1");
`endif

endmodule

`default_nettype wire
